FILE: rtl/core/b64e_pkg.sv
// Base64 stream encoder: shared types, codes and the sextet-to-character map.
// No dependencies; the front, queue, back, top and checker import this package.
package b64e_pkg;

    localparam int GROUP_W = 24;

    // Number of '=' characters that close a group.
    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;

    localparam logic [6:0] CHAR_UPPER_A = 7'd65;  // 'A'
    localparam logic [6:0] LOWER_OFFSET = 7'd71;  // 'a' - 26
    localparam logic [6:0] DIGIT_OFFSET = 7'd4;   // 52 - '0'
    localparam logic [6:0] CHAR_PLUS    = 7'd43;  // '+'
    localparam logic [6:0] CHAR_SLASH   = 7'd47;  // '/'
    localparam logic [6:0] CHAR_PAD     = 7'd61;  // '='

    localparam logic [5:0] SEXTET_LOWER = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // One finished group, as handed from the front to the back.
    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [1:0]         pad_count;
        logic               eom;
    } t_job;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < SEXTET_LOWER) begin
            c = CHAR_UPPER_A + {1'b0, v};
        end else if (v < SEXTET_DIGIT) begin
            c = {1'b0, v} + LOWER_OFFSET;
        end else if (v < SEXTET_PLUS) begin
            c = {1'b0, v} - DIGIT_OFFSET;
        end else if (v == SEXTET_PLUS) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/b64e_stream_if.sv
// Base64 stream encoder: valid/ready channel interfaces for bytes and characters.
// No dependencies.
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

FILE: rtl/core/b64e_front.sv
// Base64 stream encoder front: takes bytes, gathers groups, pushes finished jobs.
// Depends on b64e_pkg.
module b64e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    b64e_in_if.sink         i_in_ch,
    input  logic            i_q_full,
    output logic            o_push,
    output b64e_pkg::t_job  o_job
);
    import b64e_pkg::*;

    logic [15:0] r_held_bytes, n_held_bytes;
    logic [1:0]  r_held_count, n_held_count;
    logic        accept;

    assign i_in_ch.ready = !i_q_full;
    assign accept        = i_in_ch.valid && !i_q_full;

    always_comb begin
        n_held_bytes = r_held_bytes;
        n_held_count = r_held_count;
        o_push       = 1'b0;
        o_job.eom    = i_in_ch.end_of_message;
        o_job.group  = {r_held_bytes, i_in_ch.data_byte};
        o_job.pad_count = PAD_NONE;
        if (r_held_count[1]) begin
            // full group, end flag or not
            o_push = accept;
        end else if (i_in_ch.end_of_message) begin
            o_push = accept;
            if (r_held_count[0]) begin
                o_job.group     = {r_held_bytes[15:8], i_in_ch.data_byte, 8'h00};
                o_job.pad_count = PAD_ONE;
            end else begin
                o_job.group     = {i_in_ch.data_byte, 16'h0000};
                o_job.pad_count = PAD_TWO;
            end
        end
        if (accept) begin
            if (o_push) begin
                n_held_bytes = 16'h0000;
                n_held_count = 2'd0;
            end else if (r_held_count[0]) begin
                n_held_bytes = {r_held_bytes[15:8], i_in_ch.data_byte};
                n_held_count = 2'd2;
            end else begin
                n_held_bytes = {i_in_ch.data_byte, 8'h00};
                n_held_count = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bytes <= 16'h0000;
            r_held_count <= 2'd0;
        end else begin
            r_held_bytes <= n_held_bytes;
            r_held_count <= n_held_count;
        end
    end

endmodule

FILE: rtl/core/b64e_queue.sv
// Base64 stream encoder: small job queue between front and back.
// Depends on b64e_pkg.
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64e_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output b64e_pkg::t_job  o_job
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/b64e_back.sv
// Base64 stream encoder back: turns one job into four characters, one a cycle while the output is not stalled.
// Depends on b64e_pkg.
module b64e_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  b64e_pkg::t_job  i_job,
    output logic            o_pop,
    b64e_out_if.source      o_out_ch
);
    import b64e_pkg::*;

    t_job       r_job, n_job;
    logic       r_busy, n_busy;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic [6:0] r_out_char, n_out_char;
    logic       r_out_last, n_out_last;
    logic       adv, fire, done;
    logic [5:0] sextet;
    logic       is_pad;

    assign adv   = !r_out_valid || o_out_ch.ready;
    assign fire  = r_busy && adv;
    assign done  = fire && (r_idx == 2'd3);
    assign o_pop = i_q_valid && (!r_busy || done);

    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_job.group[23:18];
            2'd1:    sextet = r_job.group[17:12];
            2'd2:    sextet = r_job.group[11:6];
            default: sextet = r_job.group[5:0];
        endcase
        is_pad = ((r_idx == 2'd3) && (r_job.pad_count != PAD_NONE))
              || ((r_idx == 2'd2) && (r_job.pad_count == PAD_TWO));
    end

    always_comb begin
        n_job       = r_job;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (fire) begin
            n_out_valid = 1'b1;
            n_out_char  = is_pad ? CHAR_PAD : sextet_char(sextet);
            n_out_last  = r_job.eom && (r_idx == 2'd3);
            n_idx       = r_idx + 2'd1;
            if (done) begin
                n_busy = 1'b0;
            end
        end else if (o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end
        if (o_pop) begin
            n_job  = i_job;
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.out_char  = r_out_char;
    assign o_out_ch.last_char = r_out_last;

endmodule

FILE: rtl/core/base64_stream_encoder_top.sv
// Base64 stream encoder (standard alphabet, '=' padding): one message byte in
// per item, one ASCII character out per item. Every third byte, or the last
// byte of a message, closes a group that comes out as four characters, the
// final one of a message carrying last_char. The output register sends one
// character a cycle while the output is not stalled, and bytes of later
// groups are taken while a group's characters go out. A closing byte's group
// passes through the job queue and the back's job register before its first
// character is registered at the output.
// Input ready drops only while the job queue (QUEUE_DEPTH groups) is full.
// Depends on b64e_pkg, the channel interfaces, b64e_front, b64e_queue and
// b64e_back.
module base64_stream_encoder_top #(
    parameter int QUEUE_DEPTH = 2   // finished groups buffered, 2 or more
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64e_in_if.sink     i_in_ch,
    b64e_out_if.source  o_out_ch
);
    import b64e_pkg::*;

    // front -> queue
    logic q_push;
    t_job q_in_job;
    logic q_full;

    // queue -> back
    logic q_valid;
    logic q_pop;
    t_job q_out_job;

    // Front: holds up to two bytes of the open group; on a closing byte it
    // builds the 24-bit group (zero-filled for short groups) and the pad count.
    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (q_in_job)
    );

    // Queue: decouples byte intake from character output.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_out_job)
    );

    // Back: walks the four sextets of a group, substitutes padding, and
    // pulls the next group in the same cycle its fourth character is registered.
    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_out_job),
        .o_pop     (q_pop),
        .o_out_ch  (o_out_ch)
    );

endmodule

FILE: rtl/core/b64e_checker.sv
// Base64 stream encoder: port-level checks on the character stream.
// Depends on b64e_pkg; bound to base64_stream_encoder_top.
module b64e_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready,
    input  logic [6:0] i_out_char,
    input  logic       i_last_char
);
    import b64e_pkg::*;

    logic [1:0] r_pos;          // position of the next character in its group
    logic       r_pad_pending;  // third character of the group was padding
    logic       out_acc;

    assign out_acc = i_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= 2'd0;
            r_pad_pending <= 1'b0;
        end else if (out_acc) begin
            r_pos         <= r_pos + 2'd1;
            r_pad_pending <= (r_pos == 2'd2) && (i_out_char == CHAR_PAD);
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("character valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_char)
            && $stable(i_last_char))
        else $error("stalled character changed");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last_char |-> r_pos == 2'd3)
        else $error("last character not at end of a group");

    a_pad_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_out_char == CHAR_PAD) |-> r_pos[1])
        else $error("padding in first half of a group");

    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_pad_pending && (r_pos == 2'd3)
            |-> (i_out_char == CHAR_PAD) && i_last_char)
        else $error("double padding not closed as last character");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out_ch.valid),
    .i_ready     (o_out_ch.ready),
    .i_out_char  (o_out_ch.out_char),
    .i_last_char (o_out_ch.last_char)
);
